>>> rtl/rcf_pkg.sv
// Shared constants and types for the RIFF chunk finder.
package rcf_pkg;

  // Header magic "RIFF", first character in the low byte
  localparam logic [31:0] MAGIC_RIFF    = 32'h4646_4952;
  // Largest chunk size accepted
  localparam logic [31:0] SIZE_LIMIT    = 32'h7FFF_FFFF;
  // Reset value of the target id, "id3 "
  localparam logic [31:0] TARGET_RESET  = 32'h2033_6469;

  // Byte counts within the headers
  localparam logic [31:0] ID_LEN        = 32'd4;
  localparam logic [31:0] SIZE_END      = 32'd8;
  localparam logic [31:0] RIFF_HDR_LEN  = 32'd12;
  localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_RIFF  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } rcf_status_t;

  // Configuration register indexes
  typedef enum logic {
    REG_FILE_LENGTH = 1'b0,
    REG_TARGET_ID   = 1'b1
  } rcf_reg_t;

  // Result of one step of the walker
  typedef struct packed {
    logic        valid;
    rcf_status_t status;
    logic [31:0] chunk_length;
  } rcf_res_t;

endpackage

>>> rtl/rcf_if.sv
// Stream interfaces for the byte input and the result output.
interface rcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rcf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] chunk_length;

  modport source (output valid, output status, output chunk_length, input ready);
  modport sink   (input valid, input status, input chunk_length, output ready);
endinterface

>>> rtl/rcf_walker.sv
// Header check and chunk walk state with its next-state logic.
module rcf_walker
  import rcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  input  logic [31:0] file_length,
  input  logic [31:0] target_chunk_id,
  output rcf_res_t    res,
  output logic        decided
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] size_r, size_nxt;
  logic        decided_r, decided_nxt;
  logic [31:0] count_inc;
  logic [31:0] padded;

  assign count_inc = count_r + 32'd1;
  assign decided   = decided_r;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    id_nxt      = id_r;
    size_nxt    = size_r;
    decided_nxt = decided_r;
    padded      = '0;
    res         = '{valid: 1'b0, status: ST_FOUND, chunk_length: '0};

    if (!decided_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (count_r < ID_LEN) begin
            id_nxt = {data_byte, id_r[31:8]};
          end else if (count_r < SIZE_END) begin
            size_nxt = {data_byte, size_r[31:8]};
          end
          count_nxt = count_inc;
          if (count_inc == RIFF_HDR_LEN) begin
            if (id_nxt != MAGIC_RIFF || size_nxt > file_length) begin
              res.valid  = 1'b1;
              res.status = ST_NOT_RIFF;
            end else begin
              phase_nxt = PH_CHUNK;
              count_nxt = '0;
            end
          end
        end
        PH_CHUNK: begin
          if (count_r < ID_LEN) begin
            id_nxt = {data_byte, id_r[31:8]};
          end else begin
            size_nxt = {data_byte, size_r[31:8]};
          end
          count_nxt = count_inc;
          if (count_inc >= CHUNK_HDR_LEN) begin
            count_nxt = '0;
            padded    = size_nxt + {31'd0, size_nxt[0]};
            if (size_nxt > SIZE_LIMIT) begin
              res.valid  = 1'b1;
              res.status = ST_TOO_LARGE;
            end else if (id_nxt == target_chunk_id) begin
              res.valid        = 1'b1;
              res.status       = ST_FOUND;
              res.chunk_length = padded;
            end else if (padded != '0) begin
              phase_nxt = PH_SKIP;
              count_nxt = padded;
            end
          end
        end
        PH_SKIP: begin
          if (count_r != '0) begin
            count_nxt = count_r - 32'd1;
          end
          if (count_nxt == '0) begin
            phase_nxt = PH_CHUNK;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase

      // stream ended before any verdict
      if (!res.valid && end_of_stream) begin
        res.valid  = 1'b1;
        res.status = (phase_nxt == PH_HEADER) ? ST_NOT_RIFF : ST_NOT_FOUND;
      end
      if (res.valid) begin
        decided_nxt = 1'b1;
      end
    end

    // last byte rearms the walker
    if (end_of_stream) begin
      phase_nxt   = PH_HEADER;
      count_nxt   = '0;
      id_nxt      = '0;
      size_nxt    = '0;
      decided_nxt = 1'b0;
    end
  end

  // State registers, updated once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= '0;
      id_r      <= '0;
      size_r    <= '0;
      decided_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      id_r      <= id_nxt;
      size_r    <= size_nxt;
      decided_r <= decided_nxt;
    end
  end

endmodule

>>> rtl/riff_chunk_finder.sv
// RIFF chunk finder: input register, walker, result register, config registers.
//
// The block reads a RIFF stream one byte per word on in_ch; end_of_stream
// marks the last byte. It checks the 12-byte RIFF header against file_length,
// walks the chunk headers and skips bodies, and sends at most one result word
// per stream on out_ch: found with the padded length, not RIFF, chunk size too
// large, or not found. The last byte rearms the block for the next stream.
// Configuration: cfg_we with cfg_index 0 (file_length) or 1 (target_chunk_id)
// and cfg_data; write only while no stream is in flight.
// Throughput: one byte per cycle but for the output stall below, set by the single
// walker step that sits between the input register and the result register.
// A byte's result reaches out_ch through the input register, the walker step and the result register.
// Reset (rst_n low, synchronous) empties both registers, rearms the walker and
// returns the configuration to file_length 0 and target "id3 ".
// When out_ch stalls with a result waiting, bytes that give no result keep
// flowing; the input stalls only when a byte would produce a second result.
module riff_chunk_finder
  import rcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rcf_in_if.sink      in_ch,
  rcf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eos_r;
  logic        s1_go;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_length_r;
  logic [31:0] file_length_r;
  logic [31:0] target_id_r;
  rcf_res_t    res;
  logic        decided;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      target_id_r   <= TARGET_RESET;
    end else if (cfg_we) begin
      case (rcf_reg_t'(cfg_index))
        REG_FILE_LENGTH: file_length_r <= cfg_data;
        REG_TARGET_ID:   target_id_r   <= cfg_data;
        default:         file_length_r <= file_length_r;
      endcase
    end
  end

  // The held byte moves on unless its result would overrun a stalled output
  assign s1_go       = s1_valid_r && (!res.valid || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eos_r  <= in_ch.end_of_stream;
    end
  end

  rcf_walker u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_go),
    .data_byte       (s1_byte_r),
    .end_of_stream   (s1_eos_r),
    .file_length     (file_length_r),
    .target_chunk_id (target_id_r),
    .res             (res),
    .decided         (decided)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.valid) begin
      out_status_r <= res.status;
      out_length_r <= res.chunk_length;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chunk_length = out_length_r;

`ifndef ASSERT_OFF
  // Only a found result carries a length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_FOUND |-> out_ch.chunk_length == '0)
    else $error("non-zero length on a failed search");

  // A found length is padded to even
  a_len_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_FOUND |-> !out_ch.chunk_length[0])
    else $error("odd chunk length reported");

  // A verdict mid-stream blocks further results until the last byte
  a_decided: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && res.valid && !s1_eos_r |=> decided)
    else $error("walker not marked decided after a result");

  // No result may be produced once decided
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    decided |-> !res.valid)
    else $error("second result in one stream");
`endif

endmodule
